// ===== hdl/lspq_pkg.sv =====
// Shared types and constants for the linear scan priority queue.
// Holds the item structs, the stored entry type and the command/status codes.
// No dependencies.
package lspq_pkg;

	// Queue depth and derived widths
	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 4;

	// Command codes
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_POLL = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] elem_x;
		logic signed [31:0] elem_y;
		logic signed [31:0] prio_in;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_prio;
		logic [OCC_W-1:0]   occupancy;
	} rsp_item_t;

	// One stored queue entry
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] prio;
	} entry_t;

endpackage

// ===== hdl/linear_scan_priority_queue.sv =====
// Linear scan priority queue: CAPACITY entries of (x, y, priority) kept unsorted
// in insertion order in a one-read, one-write memory. Add appends; peek returns the
// highest-priority entry (earliest on ties); poll also removes it and shifts later
// entries down. One item is worked at a time. An add, a rejected command or an
// unused code needs no scan; for a peek or a poll the single memory read port
// reads one entry per cycle over all held entries, and on a poll then over the
// entries after the returned one for the shift.
// The result sits in an output register, so the next item is taken while it waits.
// Depends on lspq_pkg.
module linear_scan_priority_queue
	import lspq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [1:0]       cmd_q;
	logic [1:0]       status_q;
	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	// Entry memory and its registered read port
	entry_t           mem [CAPACITY];
	entry_t           rd_q;

	logic             req_acc;
	logic             rsp_free;
	logic             take;
	logic [IDX_W-1:0] best_idx_d;
	logic             ptr_end;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	entry_t           new_entry;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign ptr_end   = (ptr_q == count_q);

	assign new_entry.x    = req.elem_x;
	assign new_entry.y    = req.elem_y;
	assign new_entry.prio = req.prio_in;

	// Scan compare: first read seeds the best, later ones replace it only if strictly higher
	always_comb begin
		take = (state_q == S_SCAN) && rd_vld_q &&
			((rd_idx_q == '0) || ($signed(rd_q.prio) > $signed(best_q.prio)));
		best_idx_d = take ? rd_idx_q : best_idx_q;
	end

	// Memory write select: append on add, move down one slot during the shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = new_entry;
		if (req_acc && (req.cmd == CMD_ADD) && (count_q != CNT_W'(CAPACITY))) begin
			wr_en = 1'b1;
		end else if ((state_q == S_SHIFT) && rd_vld_q) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_q - IDX_W'(1);
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[ptr_q[IDX_W-1:0]];
	end

	// Best-entry tracking
	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= rd_q;
		end
		best_idx_q <= best_idx_d;
	end

	// Sequencer, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_vld_q    <= 1'b0;
			rd_idx_q    <= '0;
			cmd_q       <= CMD_ADD;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					ptr_q    <= '0;
					if (req_acc) begin
						cmd_q    <= req.cmd;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						if (req.cmd == CMD_ADD) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if ((req.cmd == CMD_POLL) || (req.cmd == CMD_PEEK)) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					// one read issued per cycle, compared the cycle after
					if (!ptr_end) begin
						rd_vld_q <= 1'b1;
						rd_idx_q <= ptr_q[IDX_W-1:0];
						ptr_q    <= ptr_q + CNT_W'(1);
					end else begin
						rd_vld_q <= 1'b0;
						ptr_q    <= CNT_W'(best_idx_d) + CNT_W'(1);
						state_q  <= (cmd_q == CMD_POLL) ? S_SHIFT : S_DONE;
					end
				end
				S_SHIFT: begin
					// read slot ptr, write it one slot lower next cycle
					if (!ptr_end) begin
						rd_vld_q <= 1'b1;
						rd_idx_q <= ptr_q[IDX_W-1:0];
						ptr_q    <= ptr_q + CNT_W'(1);
					end else begin
						rd_vld_q <= 1'b0;
						count_q  <= count_q - CNT_W'(1);
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.status    <= status_q;
						rsp_q.occupancy <= OCC_W'(count_q);
						if ((status_q == ST_OK) &&
							((cmd_q == CMD_POLL) || (cmd_q == CMD_PEEK))) begin
							rsp_q.out_x    <= best_q.x;
							rsp_q.out_y    <= best_q.y;
							rsp_q.out_prio <= best_q.prio;
						end else begin
							rsp_q.out_x    <= '0;
							rsp_q.out_y    <= '0;
							rsp_q.out_prio <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
